[src/maxwell_1d_stencil_update_defines.svh]
// Assertion macros shared by the checker of the stencil update block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MAXWELL_1D_STENCIL_UPDATE_DEFINES_SVH
`define MAXWELL_1D_STENCIL_UPDATE_DEFINES_SVH

// Plain property check; pass 1'b0 as rs to keep it live through reset.
`define MSU_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error(msg);

// Condition in one cycle implies expression in the next.
`define MSU_ASSERT_NEXT(lbl, ck, rs, cond, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |=> (expr)) \
    else $error(msg);

`endif

[src/msu_pkg.sv]
// Shared types and constants for the 1D stencil field update block.
// No dependencies; imported by the controller, datapath, top and checker.
package msu_pkg;

  localparam int FIELD_WIDTH_DEF = 32;
  localparam int ACC_W           = 64;   // increment accumulator, wraps
  localparam int ACC_SHIFT       = 17;   // accumulator scale 2^-33 -> Q16.16
  localparam int CRT_W           = 17;   // courant, unsigned Q1.16
  localparam int TS_W            = 24;   // time step, unsigned Q8.16
  localparam int CFG_DATA_W      = 24;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CRT_W-1:0]     COURANT_ONE   = 17'h10000;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'b1;
  localparam logic [1:0]           FILL_FULL     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B,
    ST_APPLY_B,
    ST_MUL_E,
    ST_APPLY_E
  } state_t;

  typedef struct packed {
    logic ghost;    // seed previous B from ghost cell
    logic store;    // shift arriving cell into window, no result
    logic capture;  // latch arriving cell i+2
    logic mul_b;    // courant products for B, dt products for J
    logic apply_b;  // register new B
    logic mul_e;    // courant products for E
    logic finish;   // load output register, shift window
  } cmd_t;

endpackage

[src/maxwell_1d_stencil_update.sv]
// Top level of the 1D stencil field update block.
// Instantiates msu_ctrl and msu_datapath; uses msu_pkg.
//
// Usage:
//   Config port: cfg_we/cfg_index/cfg_data write courant (index 0, clamped
//   to one) or time_step (index 1); write only while idle.
//   Input channel in_valid/in_ready carries one cell per item: first_cell
//   marks a ghost cell that only seeds the previous B and restarts the run.
//   The first two cells after a ghost are stored; each later cell i+2 emits
//   the updated cell i on the out_valid/out_ready channel.
//   Steps: ghost and fill cells are accepted in the idle state, which
//   they leave unchanged. An emitting cell steps through accept, B multiply,
//   B apply, E multiply, E apply; out_valid is registered from E apply.
//   The per-lane courant multiplier is used twice per cell, for B and E.
//   The output register frees the input side: the next item is accepted
//   while a result waits. If the receiver stalls with a result pending, the
//   next result waits in the E-apply step and in_ready stays low.
//   Reset clears config, fill count and previous B; it acts as a zero ghost.
module maxwell_1d_stencil_update #(
  parameter int FIELD_WIDTH = msu_pkg::FIELD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [msu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           first_cell,
  input  logic signed [FIELD_WIDTH-1:0]  bx_in,
  input  logic signed [FIELD_WIDTH-1:0]  by_in,
  input  logic signed [FIELD_WIDTH-1:0]  bz_in,
  input  logic signed [FIELD_WIDTH-1:0]  ex_in,
  input  logic signed [FIELD_WIDTH-1:0]  ey_in,
  input  logic signed [FIELD_WIDTH-1:0]  ez_in,
  input  logic signed [FIELD_WIDTH-1:0]  jx_in,
  input  logic signed [FIELD_WIDTH-1:0]  jy_in,
  input  logic signed [FIELD_WIDTH-1:0]  jz_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [FIELD_WIDTH-1:0]  bx_new,
  output logic signed [FIELD_WIDTH-1:0]  by_new,
  output logic signed [FIELD_WIDTH-1:0]  bz_new,
  output logic signed [FIELD_WIDTH-1:0]  bx_mid,
  output logic signed [FIELD_WIDTH-1:0]  by_mid,
  output logic signed [FIELD_WIDTH-1:0]  bz_mid,
  output logic signed [FIELD_WIDTH-1:0]  ex_new,
  output logic signed [FIELD_WIDTH-1:0]  ey_new,
  output logic signed [FIELD_WIDTH-1:0]  ez_new
);
  import msu_pkg::*;

  cmd_t cmd;

  msu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .first_cell (first_cell),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  msu_datapath #(
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bx_in     (bx_in),
    .by_in     (by_in),
    .bz_in     (bz_in),
    .ex_in     (ex_in),
    .ey_in     (ey_in),
    .ez_in     (ez_in),
    .jx_in     (jx_in),
    .jy_in     (jy_in),
    .jz_in     (jz_in),
    .bx_new    (bx_new),
    .by_new    (by_new),
    .bz_new    (bz_new),
    .bx_mid    (bx_mid),
    .by_mid    (by_mid),
    .bz_mid    (bz_mid),
    .ex_new    (ex_new),
    .ey_new    (ey_new),
    .ez_new    (ez_new)
  );

endmodule

[src/msu_ctrl.sv]
// Sequencer for the stencil update: input handshake, window fill count,
// per-cell step sequence and output valid. Uses msu_pkg.
module msu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          first_cell,
  output logic          out_valid,
  input  logic          out_ready,
  output msu_pkg::cmd_t cmd
);
  import msu_pkg::*;

  state_t     state, state_next;
  logic [1:0] fill_count, fill_count_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_comb begin
    cmd             = '0;
    in_ready        = 1'b0;
    state_next      = state;
    fill_count_next = fill_count;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (first_cell) begin
            cmd.ghost       = 1'b1;
            fill_count_next = '0;
          end else if (fill_count != FILL_FULL) begin
            cmd.store       = 1'b1;
            fill_count_next = 2'(fill_count + 2'd1);
          end else begin
            cmd.capture = 1'b1;
            state_next  = ST_MUL_B;
          end
        end
      end
      ST_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = ST_APPLY_B;
      end
      ST_APPLY_B: begin
        cmd.apply_b = 1'b1;
        state_next  = ST_MUL_E;
      end
      ST_MUL_E: begin
        cmd.mul_e  = 1'b1;
        state_next = ST_APPLY_E;
      end
      ST_APPLY_E: begin
        // wait here until the output register is free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cmd.finish)
      out_valid_next = 1'b1;
    else if (out_valid && out_ready)
      out_valid_next = 1'b0;
    else
      out_valid_next = out_valid;
  end

endmodule

[src/msu_datapath.sv]
// Datapath of the stencil update: configuration registers, two-cell window,
// three x/y/z lanes with shared courant multipliers, rounding, saturation.
// Uses msu_pkg; driven by msu_ctrl commands.
module msu_datapath #(
  parameter int FIELD_WIDTH = msu_pkg::FIELD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  msu_pkg::cmd_t                     cmd,
  input  logic                              cfg_we,
  input  logic [msu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msu_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [FIELD_WIDTH-1:0]     bx_in,
  input  logic signed [FIELD_WIDTH-1:0]     by_in,
  input  logic signed [FIELD_WIDTH-1:0]     bz_in,
  input  logic signed [FIELD_WIDTH-1:0]     ex_in,
  input  logic signed [FIELD_WIDTH-1:0]     ey_in,
  input  logic signed [FIELD_WIDTH-1:0]     ez_in,
  input  logic signed [FIELD_WIDTH-1:0]     jx_in,
  input  logic signed [FIELD_WIDTH-1:0]     jy_in,
  input  logic signed [FIELD_WIDTH-1:0]     jz_in,
  output logic signed [FIELD_WIDTH-1:0]     bx_new,
  output logic signed [FIELD_WIDTH-1:0]     by_new,
  output logic signed [FIELD_WIDTH-1:0]     bz_new,
  output logic signed [FIELD_WIDTH-1:0]     bx_mid,
  output logic signed [FIELD_WIDTH-1:0]     by_mid,
  output logic signed [FIELD_WIDTH-1:0]     bz_mid,
  output logic signed [FIELD_WIDTH-1:0]     ex_new,
  output logic signed [FIELD_WIDTH-1:0]     ey_new,
  output logic signed [FIELD_WIDTH-1:0]     ez_new
);
  import msu_pkg::*;

  localparam int FW  = FIELD_WIDTH;
  localparam int OPW = FW + 4;   // exact advection plus curl operand
  localparam int CMW = (OPW + CRT_W + 1 > ACC_W) ? OPW + CRT_W + 1 : ACC_W;
  localparam int JMW = (FW + TS_W + 1 > ACC_W) ? FW + TS_W + 1 : ACC_W;
  localparam logic [ACC_W-1:0] SAT_HI = {ACC_W{1'b1}} >> (ACC_W - FW + 1);
  localparam logic [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [ACC_W-1:0] RND    = ACC_W'(1) << (ACC_SHIFT - 1);

  typedef logic signed [FW-1:0]  fld_t;
  typedef logic signed [OPW-1:0] op_t;

  fld_t             b_in [3];
  fld_t             e_in [3];
  fld_t             j_in [3];
  fld_t             w0_b [3];   // cell i
  fld_t             w0_e [3];
  fld_t             w0_j [3];
  fld_t             w1_b [3];   // cell i+1
  fld_t             w1_e [3];
  fld_t             w1_j [3];
  fld_t             c_b  [3];   // cell i+2
  fld_t             c_e  [3];
  fld_t             c_j  [3];
  fld_t             nb   [3];
  fld_t             prev_by, prev_bz;
  logic [CRT_W-1:0] courant;
  logic [TS_W-1:0]  time_step;
  logic [ACC_W-1:0] prod_c [3];
  logic [ACC_W-1:0] prod_j [3];  // holds 2*dt*J
  op_t              op_b   [3];
  op_t              op_e   [3];
  op_t              mul_op [3];
  logic signed [CMW-1:0] cprod [3];
  logic signed [JMW-1:0] jprod [3];
  fld_t             nb_calc  [3];
  fld_t             ne_calc  [3];
  fld_t             mid_calc [3];
  fld_t             ob_new [3];
  fld_t             ob_mid [3];
  fld_t             oe_new [3];

  function automatic op_t adv3(input fld_t f0, input fld_t f1, input fld_t f2);
    op_t a0, a1, a2;
    a0 = OPW'(f0);
    a1 = OPW'(f1);
    a2 = OPW'(f2);
    return (a1 <<< 2) - (a0 <<< 1) - a0 - a2;
  endfunction

  function automatic op_t diff2(input fld_t hi, input fld_t lo);
    return (OPW'(hi) - OPW'(lo)) <<< 1;
  endfunction

  // round half up, add to old value, saturate to field range
  function automatic fld_t apply_inc(input fld_t old, input logic [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] inc, sum;
    inc = $signed(acc + RND) >>> ACC_SHIFT;
    sum = ACC_W'(old) + inc;
    if (sum > $signed(SAT_HI))
      sum = $signed(SAT_HI);
    else if (sum < $signed(SAT_LO))
      sum = $signed(SAT_LO);
    return sum[FW-1:0];
  endfunction

  function automatic fld_t mean2(input fld_t a, input fld_t b);
    logic signed [ACC_W-1:0] s;
    s = ACC_W'(a) + ACC_W'(b) + ACC_W'(1);
    s = s >>> 1;
    return s[FW-1:0];
  endfunction

  assign b_in = '{bx_in, by_in, bz_in};
  assign e_in = '{ex_in, ey_in, ez_in};
  assign j_in = '{jx_in, jy_in, jz_in};

  always_comb begin
    op_b[0] = adv3(w0_b[0], w1_b[0], c_b[0]);
    op_b[1] = adv3(w0_b[1], w1_b[1], c_b[1]) + diff2(w1_e[2], w0_e[2]);
    op_b[2] = adv3(w0_b[2], w1_b[2], c_b[2]) - diff2(w1_e[1], w0_e[1]);
    op_e[0] = adv3(w0_e[0], w1_e[0], c_e[0]);
    op_e[1] = adv3(w0_e[1], w1_e[1], c_e[1]) - diff2(nb[2], prev_bz);
    op_e[2] = adv3(w0_e[2], w1_e[2], c_e[2]) + diff2(nb[1], prev_by);
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign mul_op[k]   = cmd.mul_e ? op_e[k] : op_b[k];
    assign cprod[k]    = CMW'($signed({1'b0, courant})) * CMW'(mul_op[k]);
    assign jprod[k]    = JMW'($signed({1'b0, time_step})) * JMW'(w0_j[k]);
    assign nb_calc[k]  = apply_inc(w0_b[k], prod_c[k]);
    assign ne_calc[k]  = apply_inc(w0_e[k], prod_c[k] - prod_j[k]);
    assign mid_calc[k] = mean2(w0_b[k], nb[k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      courant   <= '0;
      time_step <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COURANT: begin
          courant <= (cfg_data[CRT_W-1:0] > COURANT_ONE) ? COURANT_ONE
                                                         : cfg_data[CRT_W-1:0];
        end
        REG_TIME_STEP: time_step <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // new B of cell i-1 feeds the E curl; a ghost seeds it with its old B
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_by <= '0;
      prev_bz <= '0;
    end else if (cmd.ghost) begin
      prev_by <= b_in[1];
      prev_bz <= b_in[2];
    end else if (cmd.finish) begin
      prev_by <= nb[1];
      prev_bz <= nb[2];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.store) begin
        w0_b[k] <= w1_b[k];
        w0_e[k] <= w1_e[k];
        w0_j[k] <= w1_j[k];
        w1_b[k] <= b_in[k];
        w1_e[k] <= e_in[k];
        w1_j[k] <= j_in[k];
      end else if (cmd.finish) begin
        w0_b[k] <= w1_b[k];
        w0_e[k] <= w1_e[k];
        w0_j[k] <= w1_j[k];
        w1_b[k] <= c_b[k];
        w1_e[k] <= c_e[k];
        w1_j[k] <= c_j[k];
      end
      if (cmd.capture) begin
        c_b[k] <= b_in[k];
        c_e[k] <= e_in[k];
        c_j[k] <= j_in[k];
      end
      if (cmd.mul_b || cmd.mul_e)
        prod_c[k] <= cprod[k][ACC_W-1:0];
      if (cmd.mul_b)
        prod_j[k] <= {jprod[k][ACC_W-2:0], 1'b0};
      if (cmd.apply_b)
        nb[k] <= nb_calc[k];
      if (cmd.finish) begin
        ob_new[k] <= nb[k];
        ob_mid[k] <= mid_calc[k];
        oe_new[k] <= ne_calc[k];
      end
    end
  end

  assign bx_new = ob_new[0];
  assign by_new = ob_new[1];
  assign bz_new = ob_new[2];
  assign bx_mid = ob_mid[0];
  assign by_mid = ob_mid[1];
  assign bz_mid = ob_mid[2];
  assign ex_new = oe_new[0];
  assign ey_new = oe_new[1];
  assign ez_new = oe_new[2];

endmodule

[src/msu_checker.sv]
// Port-level checks for the stencil update block, bound to the top level.
// Uses msu_pkg and the assertion macros header.
`include "maxwell_1d_stencil_update_defines.svh"

module msu_checker #(
  parameter int FIELD_WIDTH = msu_pkg::FIELD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [FIELD_WIDTH-1:0] bx_new,
  input logic signed [FIELD_WIDTH-1:0] by_new,
  input logic signed [FIELD_WIDTH-1:0] bz_new,
  input logic signed [FIELD_WIDTH-1:0] bx_mid,
  input logic signed [FIELD_WIDTH-1:0] by_mid,
  input logic signed [FIELD_WIDTH-1:0] bz_mid,
  input logic signed [FIELD_WIDTH-1:0] ex_new,
  input logic signed [FIELD_WIDTH-1:0] ey_new,
  input logic signed [FIELD_WIDTH-1:0] ez_new
);
  import msu_pkg::*;

  logic [9*FIELD_WIDTH-1:0] res_bus;

  assign res_bus = {bx_new, by_new, bz_new, bx_mid, by_mid, bz_mid, ex_new, ey_new, ez_new};

  // reset leaves the block idle with nothing to deliver
  `MSU_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, in_ready && !out_valid, "not idle after reset")

  // a fresh result only follows a compute step, during which input is held off
  `MSU_ASSERT(a_result_after_busy, clk, rst, $rose(out_valid) |-> $past(!in_ready), "no compute")

  `MSU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")

  `MSU_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(res_bus), "result moved")

endmodule

bind maxwell_1d_stencil_update msu_checker #(.FIELD_WIDTH(FIELD_WIDTH)) u_msu_checker (.*);
